// ===== design/rudy_congestion_patch_accumulator_core_macros.svh =====
// Assertion macros for the patch accumulator core.
`ifndef RUDY_CONGESTION_PATCH_ACCUMULATOR_CORE_MACROS_SVH
`define RUDY_CONGESTION_PATCH_ACCUMULATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RCPA_ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`define RCPA_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define RCPA_ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg)
`define RCPA_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

// ===== design/rcpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rcpa_pkg;

    localparam int COORD_BITS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 24;
    localparam int SUM_BITS_DEF      = 48;

    localparam int PATCH_W    = 32;
    localparam int SPAN_W     = 32;
    localparam int AREA_W     = 2 * SPAN_W;
    localparam int DIVISOR_W  = AREA_W + SPAN_W;
    localparam int REM_W      = DIVISOR_W + 1;
    localparam int RESULT_W   = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MODE_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PATCH_LEFT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATCH_BOTTOM   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATCH_RIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATCH_TOP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_MODE = 3'd4;

    localparam logic [MODE_W-1:0] MODE_HORIZONTAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VERTICAL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNION      = 2'd2;

    typedef struct packed {
        logic signed [31:0] pin_x;
        logic signed [31:0] pin_y;
        logic               net_end;
        logic               list_end;
    } pin_t;

    typedef struct packed {
        logic [RESULT_W-1:0] rudy_value;
        logic                saturated;
    } result_t;

    typedef struct packed {
        logic pin_load;
        logic clip_en;
        logic prod_en;
        logic mul_lo_en;
        logic mul_hi_en;
        logic span_vert;
        logic div_init;
        logic div_step;
        logic add_en;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic overlap_ok;
        logic div_done;
        logic mode_vert;
        logic mode_union;
    } status_t;

endpackage

`default_nettype wire

// ===== design/rcpa_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rcpa_dpath #(
    parameter int COORD_BITS    = rcpa_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = rcpa_pkg::FRACTION_BITS_DEF,
    parameter int SUM_BITS      = rcpa_pkg::SUM_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rcpa_pkg::pin_t                      s_data,
    input  logic                                cfg_we,
    input  logic [rcpa_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [rcpa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  rcpa_pkg::cmd_t                      cmd,
    output rcpa_pkg::status_t                   status,
    output rcpa_pkg::result_t                   m_data
);

    localparam int XW    = rcpa_pkg::PATCH_W + 1;
    localparam int QW    = FRACTION_BITS + 1;
    localparam int ACC_W = SUM_BITS + 2;
    localparam int CNT_W = $clog2(FRACTION_BITS + 1);
    localparam int SW    = rcpa_pkg::SPAN_W;
    localparam int AW    = rcpa_pkg::AREA_W;
    localparam int DW    = rcpa_pkg::DIVISOR_W;
    localparam int RW    = rcpa_pkg::REM_W;

    localparam logic signed [COORD_BITS-1:0] BOX_HI = {1'b0, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] BOX_LO = {1'b1, {(COORD_BITS - 1){1'b0}}};
    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FRACTION_BITS);

    function automatic logic signed [XW-1:0] ext_box(input logic signed [COORD_BITS-1:0] b);
        ext_box = $signed({{(XW - COORD_BITS){b[COORD_BITS-1]}}, b});
    endfunction

    function automatic logic signed [XW-1:0] ext_patch(
        input logic signed [rcpa_pkg::PATCH_W-1:0] p
    );
        ext_patch = $signed({p[rcpa_pkg::PATCH_W-1], p});
    endfunction

    function automatic logic positive(input logic signed [XW-1:0] v);
        positive = !v[XW-1] && (v != '0);
    endfunction

    // Configuration registers.
    logic signed [rcpa_pkg::PATCH_W-1:0] left_reg, bottom_reg, right_reg, top_reg;
    logic [rcpa_pkg::MODE_W-1:0]         mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            bottom_reg <= '0;
            right_reg  <= '0;
            top_reg    <= '0;
            mode_reg   <= rcpa_pkg::MODE_UNION;
        end else if (cfg_we) begin
            case (cfg_addr)
                rcpa_pkg::CFG_PATCH_LEFT:     left_reg   <= $signed(cfg_wdata);
                rcpa_pkg::CFG_PATCH_BOTTOM:   bottom_reg <= $signed(cfg_wdata);
                rcpa_pkg::CFG_PATCH_RIGHT:    right_reg  <= $signed(cfg_wdata);
                rcpa_pkg::CFG_PATCH_TOP:      top_reg    <= $signed(cfg_wdata);
                rcpa_pkg::CFG_DIRECTION_MODE: mode_reg   <= cfg_wdata[rcpa_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign status.mode_vert  = (mode_reg == rcpa_pkg::MODE_VERTICAL);
    assign status.mode_union = (mode_reg != rcpa_pkg::MODE_VERTICAL) &&
                               (mode_reg != rcpa_pkg::MODE_HORIZONTAL);

    // Running bounding box of the current net.
    logic signed [COORD_BITS-1:0] min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    logic signed [COORD_BITS-1:0] min_x_next, min_y_next, max_x_next, max_y_next;
    logic signed [COORD_BITS-1:0] pin_x_c, pin_y_c;

    assign pin_x_c = $signed(s_data.pin_x[COORD_BITS-1:0]);
    assign pin_y_c = $signed(s_data.pin_y[COORD_BITS-1:0]);

    always_comb begin
        min_x_next = min_x_reg;
        min_y_next = min_y_reg;
        max_x_next = max_x_reg;
        max_y_next = max_y_reg;
        if (cmd.clip_en) begin
            min_x_next = BOX_HI;
            min_y_next = BOX_HI;
            max_x_next = BOX_LO;
            max_y_next = BOX_LO;
        end else if (cmd.pin_load) begin
            if (pin_x_c < min_x_reg) min_x_next = pin_x_c;
            if (pin_y_c < min_y_reg) min_y_next = pin_y_c;
            if (pin_x_c > max_x_reg) max_x_next = pin_x_c;
            if (pin_y_c > max_y_reg) max_y_next = pin_y_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg <= BOX_HI;
            min_y_reg <= BOX_HI;
            max_x_reg <= BOX_LO;
            max_y_reg <= BOX_LO;
        end else begin
            min_x_reg <= min_x_next;
            min_y_reg <= min_y_next;
            max_x_reg <= max_x_next;
            max_y_reg <= max_y_next;
        end
    end

    // Clip the box to the patch and take the spans.
    logic signed [XW-1:0] bx0, by0, bx1, by1, pl, pb, pr, pt;
    logic signed [XW-1:0] olx, oly, oux, ouy, hs, vs;
    logic signed [XW-1:0] pw_reg, ph_reg, ow_reg, oh_reg;
    logic [SW-1:0]        hspan_reg, vspan_reg;

    always_comb begin
        bx0 = ext_box(min_x_reg);
        by0 = ext_box(min_y_reg);
        bx1 = ext_box(max_x_reg);
        by1 = ext_box(max_y_reg);
        pl  = ext_patch(left_reg);
        pb  = ext_patch(bottom_reg);
        pr  = ext_patch(right_reg);
        pt  = ext_patch(top_reg);
        olx = (bx0 > pl) ? bx0 : pl;
        oly = (by0 > pb) ? by0 : pb;
        oux = (bx1 < pr) ? bx1 : pr;
        ouy = (by1 < pt) ? by1 : pt;
        hs  = by1 - by0;
        vs  = bx1 - bx0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.clip_en) begin
            pw_reg    <= pr - pl;
            ph_reg    <= pt - pb;
            ow_reg    <= oux - olx;
            oh_reg    <= ouy - oly;
            hspan_reg <= (hs[SW-1:0] == '0) ? SW'(1) : hs[SW-1:0];
            vspan_reg <= (vs[SW-1:0] == '0) ? SW'(1) : vs[SW-1:0];
        end
    end

    assign status.overlap_ok = positive(pw_reg) && positive(ph_reg) &&
                               positive(ow_reg) && positive(oh_reg);

    // Products: patch area, overlap area, then the divisor in two halves.
    logic [AW-1:0] area_reg, ov_reg, p_lo_reg, p_hi_reg;
    logic [SW-1:0] span_sel;

    assign span_sel = cmd.span_vert ? vspan_reg : hspan_reg;

    always_ff @(posedge aclk) begin
        if (cmd.prod_en) begin
            area_reg <= AW'(pw_reg[SW-1:0]) * AW'(ph_reg[SW-1:0]);
            ov_reg   <= AW'(ow_reg[SW-1:0]) * AW'(oh_reg[SW-1:0]);
        end
        if (cmd.mul_lo_en) begin
            p_lo_reg <= AW'(span_sel) * AW'(area_reg[SW-1:0]);
        end
        if (cmd.mul_hi_en) begin
            p_hi_reg <= AW'(span_sel) * AW'(area_reg[AW-1:SW]);
        end
    end

    // Restoring division, one quotient bit per cycle.
    logic [DW-1:0]    d_reg;
    logic [RW-1:0]    rem_reg, rem_shift;
    logic [QW-1:0]    q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             ge;

    assign rem_shift = (cnt_reg == '0) ? rem_reg : (rem_reg << 1);
    assign ge        = rem_shift >= {1'b0, d_reg};
    assign status.div_done = (cnt_reg == LAST_STEP);

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            d_reg   <= DW'(p_lo_reg) + (DW'(p_hi_reg) << SW);
            rem_reg <= RW'(ov_reg);
            q_reg   <= '0;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= ge ? (rem_shift - {1'b0, d_reg}) : rem_shift;
            q_reg   <= {q_reg[QW-2:0], ge};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // Saturating accumulator and result register.
    logic [SUM_BITS-1:0] sum_reg;
    logic                clipped_reg;
    logic [ACC_W-1:0]    acc;
    rcpa_pkg::result_t   out_reg;

    assign acc = ACC_W'(sum_reg) + ACC_W'(q_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            clipped_reg <= 1'b0;
        end else if (cmd.emit) begin
            sum_reg     <= '0;
            clipped_reg <= 1'b0;
        end else if (cmd.add_en) begin
            if (acc > ACC_W'(SUM_MAX)) begin
                sum_reg     <= SUM_MAX;
                clipped_reg <= 1'b1;
            end else begin
                sum_reg <= acc[SUM_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg.rudy_value <= rcpa_pkg::RESULT_W'(sum_reg);
            out_reg.saturated  <= clipped_reg;
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

// ===== design/rcpa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rcpa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              pin_net_end,
    input  logic              pin_list_end,
    output logic              m_valid,
    input  logic              m_ready,
    input  rcpa_pkg::status_t status,
    output rcpa_pkg::cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CLIP   = 4'd1;
    localparam logic [3:0] ST_PROD   = 4'd2;
    localparam logic [3:0] ST_MUL_LO = 4'd3;
    localparam logic [3:0] ST_MUL_HI = 4'd4;
    localparam logic [3:0] ST_DINIT  = 4'd5;
    localparam logic [3:0] ST_DIV    = 4'd6;
    localparam logic [3:0] ST_ADD    = 4'd7;
    localparam logic [3:0] ST_EMIT   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       list_pend_reg, list_pend_next;
    logic       second_reg, second_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept, out_free;
    logic [3:0] done_state;

    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign done_state = list_pend_reg ? ST_EMIT : ST_IDLE;
    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;

    always_comb begin
        state_next     = state_reg;
        list_pend_next = list_pend_reg;
        second_next    = second_reg;
        cmd            = '0;
        cmd.span_vert  = second_reg || status.mode_vert;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.pin_load   = 1'b1;
                    list_pend_next = pin_list_end;
                    if (pin_net_end || pin_list_end) begin
                        state_next = ST_CLIP;
                    end
                end
            end
            ST_CLIP: begin
                cmd.clip_en = 1'b1;
                state_next  = ST_PROD;
            end
            ST_PROD: begin
                cmd.prod_en = 1'b1;
                second_next = 1'b0;
                state_next  = status.overlap_ok ? ST_MUL_LO : done_state;
            end
            ST_MUL_LO: begin
                cmd.mul_lo_en = 1'b1;
                state_next    = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_hi_en = 1'b1;
                state_next    = ST_DINIT;
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.add_en = 1'b1;
                if (status.mode_union && !second_reg) begin
                    second_next = 1'b1;
                    state_next  = ST_MUL_LO;
                end else begin
                    state_next = done_state;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit       = 1'b1;
                    list_pend_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = cmd.emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            list_pend_reg <= 1'b0;
            second_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            list_pend_reg <= list_pend_next;
            second_reg    <= second_next;
            m_valid_reg   <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/rudy_congestion_patch_accumulator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "rudy_congestion_patch_accumulator_core_macros.svh"

// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    pin_t: pin_x, pin_y, net_end, list_end
// m_        out        m_valid/m_ready    result_t: rudy_value, saturated
// cfg_      in         cfg_we             cfg_addr selects the register, cfg_wdata
//
// A pin that does not end a net only updates the box. A net end clips the box and forms
// the areas, and stops when the box misses the patch; else per term, one or two by direction
// mode, it forms the divisor, runs the restoring divider, one quotient bit per cycle, and adds.
// A list end then loads the result register and waits while that register is full.
// Reset is synchronous and active low; it clears the box, the sum and the configuration.

module rudy_congestion_patch_accumulator_core #(
    parameter int COORD_BITS    = rcpa_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = rcpa_pkg::FRACTION_BITS_DEF,
    parameter int SUM_BITS      = rcpa_pkg::SUM_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rcpa_pkg::pin_t                  s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output rcpa_pkg::result_t               m_data,
    input  logic                            cfg_we,
    input  logic [rcpa_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [rcpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    rcpa_pkg::cmd_t    cmd;
    rcpa_pkg::status_t status;

    rcpa_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .pin_net_end  (s_data.net_end),
        .pin_list_end (s_data.list_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .status       (status),
        .cmd          (cmd)
    );

    rcpa_dpath #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .SUM_BITS      (SUM_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_data    (m_data)
    );

    `RCPA_ASSERT_IMPLIES(a_emit_into_free, aclk, aresetn, cmd.emit, !m_valid || m_ready, "result loaded over a pending transfer")
    `RCPA_ASSERT_NEXT(a_emit_valid, aclk, aresetn, cmd.emit, m_valid, "loaded result not offered")
    `RCPA_ASSERT_NEXT(a_list_end_stalls, aclk, aresetn, s_valid && s_ready && s_data.list_end, !s_ready, "input taken before list closed")

endmodule

`default_nettype wire
